@@ rtl/core/karplus_strong_pluck_macros.svh @@
// Assertion helpers used by the files of the plucked-string block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef KARPLUS_STRONG_PLUCK_MACROS_SVH
`define KARPLUS_STRONG_PLUCK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ksp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ksp_pkg;

  // Register field widths.
  localparam int unsigned DL_W       = 11;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PICK_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OP_W       = 2;

  // Register reset values.
  localparam logic [DL_W-1:0]   DL_RESET     = 11'd2;
  localparam logic [COEF_W-1:0] BRIGHT_RESET = 16'd32768;
  localparam logic [COEF_W-1:0] DAMP_RESET   = 16'd32768;
  localparam logic [COEF_W-1:0] FBK_RESET    = 16'd65437;
  localparam logic [PICK_W-1:0] PICK_RESET   = 10'd1;

  // Unity in Q0.16, one bit wider than a coefficient.
  localparam logic [COEF_W:0] COEF_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH = 3'd0,
    CFG_BRIGHTNESS   = 3'd1,
    CFG_DAMPING      = 3'd2,
    CFG_FEEDBACK     = 3'd3,
    CFG_PICK_OFFSET  = 3'd4
  } ksp_cfg_e;

  typedef enum logic [OP_W-1:0] {
    OP_RESTART = 2'd0,
    OP_EXCITE  = 2'd1,
    OP_TICK    = 2'd2
  } ksp_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EX_MUL,
    ST_EX_ACC,
    ST_EX_COMB,
    ST_TK_MUL,
    ST_TK_FILT,
    ST_TK_GAIN,
    ST_TK_WB
  } ksp_state_e;

endpackage

`default_nettype wire

@@ rtl/core/ksp_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input item channel: an operation code and one noise sample.
interface ksp_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic signed [SAMPLE_BITS-1:0] noise_sample;

  modport source (output valid, output operation, output noise_sample, input ready);
  modport sink   (input valid, input operation, input noise_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ksp_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Output item channel: one audio sample per tick.
interface ksp_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink   (input valid, input audio_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/karplus_strong_pluck.sv @@
// Plucked-string synthesizer with a RAM delay line and a RAM raw-excitation store.
// Restart, an ignored excite and an unused operation are done in the idle state; an
// excite steps through multiply, accumulate and comb states, a tick through multiply,
// filter, gain and write-back states, waiting in multiply while the previous sample is
// unclaimed; its sample is registered as it leaves that state. After reset registers
// take their defaults and a clearing pass zeroes the delay line, accepting no item.
`timescale 1ns / 1ps
`default_nettype none
`include "karplus_strong_pluck_macros.svh"

module karplus_strong_pluck #(
  parameter int unsigned MAX_DELAY   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  ksp_in_if.sink                                item_i,
  ksp_out_if.source                             result_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ksp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ksp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import ksp_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned AW   = $clog2(MAX_DELAY);
  localparam int unsigned LW   = $clog2(MAX_DELAY + 1);
  localparam int unsigned CW   = (LW > DL_W) ? LW : DL_W;
  localparam int unsigned WIDE = SB + 19;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_DELAY - 1);
  localparam logic signed [WIDE-1:0] SAT_HI = {{(WIDE-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [WIDE-1:0] SAT_LO = {{(WIDE-SB+1){1'b1}}, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] sat_f(input logic signed [WIDE-1:0] x);
    logic signed [SB-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = x[SB-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [DL_W-1:0]   delay_length_q;
  logic [COEF_W-1:0] brightness_q;
  logic [COEF_W-1:0] damping_q;
  logic [COEF_W-1:0] feedback_q;
  logic [PICK_W-1:0] pick_offset_q;

  // Control state.
  ksp_state_e state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] play_q;
  logic [LW-1:0] load_q;
  logic          out_valid_q;
  logic signed [SB-1:0] lp_q;
  logic signed [SB-1:0] loop_q;

  // Datapath registers.
  logic signed [SB-1:0]   noise_q;
  logic signed [SB+17:0]  prod_q;
  logic signed [SB+16:0]  pa_q;
  logic signed [SB+17:0]  pb_q;
  logic signed [SB+16:0]  pf_q;
  logic signed [SB-1:0]   audio_q;

  // Memory ports.
  logic          line_we, line_re, raw_we, raw_re;
  logic [AW-1:0] line_waddr, raw_waddr, raw_raddr;
  logic [SB-1:0] line_wdata, line_rdata, raw_rdata;

  // Decodes and derived values.
  logic          in_acc, out_free, load_full, comb_on;
  ksp_op_e       op;
  logic [CW-1:0] dl_ext, len_w, pick_w;
  logic [LW-1:0] len, pick, next_idx;
  logic signed [SB:0]     diff;
  logic signed [SB-1:0]   lp_next, comb_v, loop_next, wb_v;
  logic signed [WIDE-1:0] lp_sum, comb_sum, filt_sum, fb_sh;

  assign op       = ksp_op_e'(item_i.operation);
  assign in_acc   = item_i.valid && item_i.ready;
  assign out_free = !out_valid_q || result_o.ready;

  // Effective length in [2, MAX_DELAY] and pick distance in [1, len-1].
  always_comb begin
    dl_ext = CW'(delay_length_q);
    if (dl_ext < CW'(2)) begin
      len_w = CW'(2);
    end else if (dl_ext > CW'(MAX_DELAY)) begin
      len_w = CW'(MAX_DELAY);
    end else begin
      len_w = dl_ext;
    end
    if (pick_offset_q == '0) begin
      pick_w = CW'(1);
    end else if (CW'(pick_offset_q) > len_w - CW'(1)) begin
      pick_w = len_w - CW'(1);
    end else begin
      pick_w = CW'(pick_offset_q);
    end
  end

  assign len       = len_w[LW-1:0];
  assign pick      = pick_w[LW-1:0];
  assign load_full = load_q >= len;
  assign comb_on   = load_q >= pick;
  assign next_idx  = LW'(play_q) + LW'(1);

  // Excitation lowpass and comb arithmetic.
  assign diff     = (SB+1)'(noise_q) - (SB+1)'(lp_q);
  assign lp_sum   = WIDE'(lp_q) + WIDE'(prod_q >>> 16);
  assign lp_next  = sat_f(lp_sum);
  assign comb_sum = WIDE'(lp_q) - WIDE'($signed(raw_rdata));
  assign comb_v   = comb_on ? sat_f(comb_sum) : lp_q;

  // Loop filter and feedback gain arithmetic.
  assign filt_sum  = WIDE'(pa_q) + WIDE'(pb_q);
  assign loop_next = sat_f(filt_sum >>> 16);
  assign fb_sh     = WIDE'(pf_q >>> 16);
  assign wb_v      = sat_f(fb_sh);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_EXCITE: if (!load_full) state_d = ST_EX_MUL;
            OP_TICK:   state_d = ST_TK_MUL;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_EX_MUL:  state_d = ST_EX_ACC;
      ST_EX_ACC:  state_d = ST_EX_COMB;
      ST_EX_COMB: state_d = ST_IDLE;
      ST_TK_MUL: begin
        if (out_free) state_d = ST_TK_FILT;
      end
      ST_TK_FILT: state_d = ST_TK_GAIN;
      ST_TK_GAIN: state_d = ST_TK_WB;
      ST_TK_WB:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory port control.
  always_comb begin
    item_i.ready = 1'b0;
    line_we      = 1'b0;
    line_waddr   = play_q;
    line_wdata   = wb_v;
    line_re      = 1'b0;
    raw_we       = 1'b0;
    raw_waddr    = load_q[AW-1:0];
    raw_re       = 1'b0;
    raw_raddr    = AW'(load_q - pick);
    case (state_q)
      ST_CLEAR: begin
        line_we    = 1'b1;
        line_waddr = clr_q;
        line_wdata = '0;
      end
      ST_IDLE: begin
        item_i.ready = 1'b1;
        line_re      = item_i.valid && (op == OP_TICK);
        raw_re       = item_i.valid && (op == OP_EXCITE);
      end
      ST_EX_ACC: begin
        raw_we = 1'b1;
      end
      ST_EX_COMB: begin
        line_we    = 1'b1;
        line_waddr = load_q[AW-1:0];
        line_wdata = comb_v;
      end
      ST_TK_WB: begin
        line_we = 1'b1;
      end
      default: begin
        line_we = 1'b0;
      end
    endcase
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.audio_out = audio_q;

  // Delay line and raw excitation store.
  ksp_ram #(
    .DEPTH(MAX_DELAY),
    .WIDTH(SB)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(line_waddr),
    .wdata_i(line_wdata),
    .re_i   (line_re),
    .raddr_i(play_q),
    .rdata_o(line_rdata)
  );

  ksp_ram #(
    .DEPTH(MAX_DELAY),
    .WIDTH(SB)
  ) u_raw (
    .clk_i  (clk_i),
    .we_i   (raw_we),
    .waddr_i(raw_waddr),
    .wdata_i(lp_next),
    .re_i   (raw_re),
    .raddr_i(raw_raddr),
    .rdata_o(raw_rdata)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q <= DL_RESET;
      brightness_q   <= BRIGHT_RESET;
      damping_q      <= DAMP_RESET;
      feedback_q     <= FBK_RESET;
      pick_offset_q  <= PICK_RESET;
    end else if (cfg_we_i) begin
      case (ksp_cfg_e'(cfg_idx_i))
        CFG_DELAY_LENGTH: delay_length_q <= cfg_data_i[DL_W-1:0];
        CFG_BRIGHTNESS:   brightness_q   <= cfg_data_i[COEF_W-1:0];
        CFG_DAMPING:      damping_q      <= cfg_data_i[COEF_W-1:0];
        CFG_FEEDBACK:     feedback_q     <= cfg_data_i[COEF_W-1:0];
        CFG_PICK_OFFSET:  pick_offset_q  <= cfg_data_i[PICK_W-1:0];
        default:          pick_offset_q  <= pick_offset_q;
      endcase
    end
  end

  // Control state and filter memories.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      play_q      <= '0;
      load_q      <= '0;
      out_valid_q <= 1'b0;
      lp_q        <= '0;
      loop_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      // Output register: filled by a tick, emptied when the item is taken.
      if (state_q == ST_TK_MUL && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_IDLE && in_acc && op == OP_RESTART) begin
        lp_q   <= '0;
        loop_q <= '0;
        play_q <= '0;
        load_q <= '0;
      end
      if (state_q == ST_EX_ACC)  lp_q   <= lp_next;
      if (state_q == ST_EX_COMB) load_q <= load_q + LW'(1);
      if (state_q == ST_TK_FILT) loop_q <= loop_next;
      if (state_q == ST_TK_WB) begin
        play_q <= (next_idx >= len) ? '0 : next_idx[AW-1:0];
      end
    end
  end

  // Products and sample registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) noise_q <= item_i.noise_sample;
    if (state_q == ST_EX_MUL) prod_q <= $signed({1'b0, brightness_q}) * diff;
    if (state_q == ST_TK_MUL && out_free) begin
      audio_q <= $signed(line_rdata);
      pa_q    <= $signed({1'b0, damping_q}) * $signed(line_rdata);
      pb_q    <= $signed({1'b0, COEF_ONE - {1'b0, damping_q}}) * loop_q;
    end
    if (state_q == ST_TK_GAIN) pf_q <= $signed({1'b0, feedback_q}) * loop_q;
  end

  // Checks on the sequencing of items.
  `KSP_ASSERT_NOW(a_tick_result, state_q == ST_TK_FILT, out_valid_q, "tick left without a sample")
  `KSP_ASSERT_NEXT(a_load_step, state_q == ST_EX_COMB, load_q == $past(load_q) + 1'b1, "load count did not advance")
  `KSP_ASSERT_NEXT(a_full_drop, in_acc && op == OP_EXCITE && load_full, state_q == ST_IDLE, "excite on a full line was not dropped")

endmodule

`default_nettype wire

@@ rtl/core/ksp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ksp_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
